// ----- sv/slip_frame_decoder_top_macros.svh -----
// Assertion macros for the SLIP frame decoder checker.
// No dependencies; included by the checker file.
`ifndef SLIP_FRAME_DECODER_TOP_MACROS_SVH
`define SLIP_FRAME_DECODER_TOP_MACROS_SVH

// Clocked assertion with asynchronous active-low reset disable
`define SFD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication form: antecedent holds, consequent must hold in the same cycle
`define SFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  `SFD_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ----- sv/sfd_pkg.sv -----
// Package for the SLIP frame decoder: SLIP byte codes, default frame limit
// and the result record type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

  localparam int unsigned MaxFrameDefault = 256;

  localparam logic [7:0] SlipEnd    = 8'hC0;
  localparam logic [7:0] SlipEsc    = 8'hDB;
  localparam logic [7:0] SlipEscEnd = 8'hDC;
  localparam logic [7:0] SlipEscEsc = 8'hDD;

  localparam logic KindByte = 1'b0;
  localparam logic KindEnd  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic [8:0]  frame_length;
    logic [7:0]  frame_type;
    logic        frame_had_error;
    logic [31:0] error_total;
    logic [31:0] frame_total;
  } result_t;

endpackage

`default_nettype wire

// ----- sv/slip_frame_decoder_top.sv -----
// SLIP receive decoder, top level. Depends on sfd_pkg.
// Decodes one raw link byte per request into payload bytes and frame ends.
//
// Usage:
//   Input channel: in_valid_i / in_stall_o carry raw_byte_i, one link byte
//   per request. Output channel: out_valid_o / out_stall_i carry one result
//   (kind_o 0 payload byte with its index, kind_o 1 frame end with length,
//   type, error flag) plus the running error and frame totals.
//   Result: a result is registered and appears in the cycle after its byte is taken.
//   Throughput: one byte per cycle while in_stall_o is low; the decode and state
//   update sit between the input and the single result register, and bytes that
//   give no result (pre-sync bytes, ESC, empty END, overflow bytes) are still taken.
//   Stall: while a result waits under out_stall_i, in_stall_o is raised, so
//   the result register holds and no byte is lost. As soon as the result is
//   taken a new byte is taken in the same cycle.
//   Reset: rst_ni low clears sync, escape state, frame fill and both
//   totals; bytes are then dropped until the first END.
`timescale 1ns / 1ps
`default_nettype none

module slip_frame_decoder_top import sfd_pkg::*; #(
  parameter int unsigned MAX_FRAME = MaxFrameDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  raw_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             kind_o,
  output logic [7:0]       data_byte_o,
  output logic [7:0]       byte_index_o,
  output logic [8:0]       frame_length_o,
  output logic [7:0]       frame_type_o,
  output logic             frame_had_error_o,
  output logic [31:0]      error_total_o,
  output logic [31:0]      frame_total_o
);

  localparam int unsigned FillW = $clog2(MAX_FRAME + 1);
  localparam logic [FillW-1:0] FillMax = FillW'(MAX_FRAME);

  logic             sync_q, sync_d;
  logic             esc_q, esc_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [7:0]       type_q, type_d;
  logic             err_in_q, err_in_d;
  logic [31:0]      err_cnt_q, err_cnt_d;
  logic [31:0]      frm_cnt_q, frm_cnt_d;

  logic    out_valid_q, out_valid_d;
  result_t res_q, res_d;

  logic        in_acc;
  logic        emit;
  logic        keep;
  logic [7:0]  dec_byte;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  always_comb begin
    sync_d    = sync_q;
    esc_d     = esc_q;
    fill_d    = fill_q;
    type_d    = type_q;
    err_in_d  = err_in_q;
    err_cnt_d = err_cnt_q;
    frm_cnt_d = frm_cnt_q;
    keep      = 1'b0;
    emit      = 1'b0;
    dec_byte  = raw_byte_i;
    res_d     = '0;

    if (in_acc) begin
      if (!sync_q) begin
        if (raw_byte_i == SlipEnd) begin
          sync_d   = 1'b1;
          esc_d    = 1'b0;
          fill_d   = '0;
          err_in_d = 1'b0;
          type_d   = '0;
        end
      end else if (esc_q) begin
        esc_d = 1'b0;
        keep  = 1'b1;
        case (raw_byte_i)
          SlipEscEnd: dec_byte = SlipEnd;
          SlipEscEsc: dec_byte = SlipEsc;
          default: begin
            err_cnt_d = err_cnt_q + 32'd1;
            err_in_d  = 1'b1;
          end
        endcase
      end else if (raw_byte_i == SlipEnd) begin
        if (fill_q == '0) begin
          err_in_d = 1'b0;
        end else begin
          frm_cnt_d             = frm_cnt_q + 32'd1;
          emit                  = 1'b1;
          res_d.kind            = KindEnd;
          res_d.frame_length    = 9'(fill_q);
          res_d.frame_type      = type_q;
          res_d.frame_had_error = err_in_q;
          fill_d                = '0;
          err_in_d              = 1'b0;
          type_d                = '0;
        end
      end else if (raw_byte_i == SlipEsc) begin
        esc_d = 1'b1;
      end else begin
        keep = 1'b1;
      end

      if (keep && fill_q != FillMax) begin
        emit             = 1'b1;
        res_d.kind       = KindByte;
        res_d.data_byte  = dec_byte;
        res_d.byte_index = 8'(fill_q);
        fill_d           = fill_q + FillW'(1);
        if (fill_q == '0) begin
          type_d = dec_byte;
        end
      end
    end

    res_d.error_total = err_cnt_d;
    res_d.frame_total = frm_cnt_d;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q      <= 1'b0;
      esc_q       <= 1'b0;
      fill_q      <= '0;
      type_q      <= '0;
      err_in_q    <= 1'b0;
      err_cnt_q   <= '0;
      frm_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sync_q      <= sync_d;
      esc_q       <= esc_d;
      fill_q      <= fill_d;
      type_q      <= type_d;
      err_in_q    <= err_in_d;
      err_cnt_q   <= err_cnt_d;
      frm_cnt_q   <= frm_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = res_q.kind;
  assign data_byte_o       = res_q.data_byte;
  assign byte_index_o      = res_q.byte_index;
  assign frame_length_o    = res_q.frame_length;
  assign frame_type_o      = res_q.frame_type;
  assign frame_had_error_o = res_q.frame_had_error;
  assign error_total_o     = res_q.error_total;
  assign frame_total_o     = res_q.frame_total;

endmodule

`default_nettype wire

// ----- sv/sfd_checker.sv -----
// Port-level checker for slip_frame_decoder_top, bound to the top level.
// Depends on slip_frame_decoder_top_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "slip_frame_decoder_top_macros.svh"

module sfd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic [7:0]  raw_byte_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        kind_o,
  input wire logic [7:0]  data_byte_o,
  input wire logic [7:0]  byte_index_o,
  input wire logic [8:0]  frame_length_o,
  input wire logic [7:0]  frame_type_o,
  input wire logic        frame_had_error_o,
  input wire logic [31:0] error_total_o,
  input wire logic [31:0] frame_total_o
);

  logic out_acc;
  assign out_acc = out_valid_o & ~out_stall_i;

  // a waiting result holds until taken
  `SFD_ASSERT(a_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable({kind_o, data_byte_o, byte_index_o, frame_length_o, frame_type_o, frame_had_error_o, error_total_o, frame_total_o})), "stalled result changed")

  // only a waiting, stalled result may hold off the input
  `SFD_ASSERT_IMP(a_ready, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i, "input stalled without a blocked result")

  // frame ends always report a non-empty frame
  `SFD_ASSERT_IMP(a_len, clk_i, rst_ni, out_valid_o && kind_o, frame_length_o != 9'd0, "empty frame reported")

  // the first byte after a frame end starts at index zero
  `SFD_ASSERT(a_first, clk_i, rst_ni, (out_acc && kind_o) ##1 (out_valid_o && !kind_o) |-> (byte_index_o == 8'd0), "first byte of frame not at index zero")

endmodule

bind slip_frame_decoder_top sfd_checker u_sfd_checker (.*);

`default_nettype wire
